// ===== rtl/aart_pkg.sv =====
package aart_pkg;

    // coordinate width of the point and translation fields
    localparam int COORD_WIDTH = 32;

    // pipeline geometry shared by the top level and the checker
    localparam int SQRT_CELLS = 32;
    localparam int DIV_CELLS  = 32;
    localparam int L_SIDE     = 3;
    localparam int L_LEN      = 5;
    localparam int L_ROOT     = L_LEN + SQRT_CELLS;
    localparam int L_NUM      = L_ROOT + 1;
    localparam int L_QUO      = L_NUM + DIV_CELLS;
    localparam int L_U        = L_QUO + 1;
    localparam int L_OUT      = L_U + 6;

    typedef logic signed [33:0] q_t;

    localparam q_t Q_ONE     = 34'sd1073741824;
    localparam q_t Q_MONE    = -34'sd1073741824;
    localparam q_t Q_HALF_PI = 34'sd1686629713;
    localparam q_t Q_PI      = 34'sd3373259426;
    localparam q_t Q_GAIN    = 34'sd652032874;

    typedef struct packed {
        logic signed [31:0] rot_angle;
        logic signed [COORD_WIDTH-1:0] first_point_x;
        logic signed [COORD_WIDTH-1:0] first_point_y;
        logic signed [COORD_WIDTH-1:0] first_point_z;
        logic signed [COORD_WIDTH-1:0] second_point_x;
        logic signed [COORD_WIDTH-1:0] second_point_y;
        logic signed [COORD_WIDTH-1:0] second_point_z;
    } req_t;

    typedef struct packed {
        logic signed [31:0] rot_r0c0;
        logic signed [31:0] rot_r0c1;
        logic signed [31:0] rot_r0c2;
        logic signed [31:0] rot_r1c0;
        logic signed [31:0] rot_r1c1;
        logic signed [31:0] rot_r1c2;
        logic signed [31:0] rot_r2c0;
        logic signed [31:0] rot_r2c1;
        logic signed [31:0] rot_r2c2;
        logic signed [COORD_WIDTH-1:0] shift_x;
        logic signed [COORD_WIDTH-1:0] shift_y;
        logic signed [COORD_WIDTH-1:0] shift_z;
    } res_t;

    // cordic cell state
    typedef struct packed {
        q_t   x;
        q_t   y;
        q_t   z;
        logic flip;
    } cord_t;

    // square root cell state
    typedef struct packed {
        logic [62:0] x;
        logic [62:0] r;
    } sqrt_t;

    // divider cell state
    typedef struct packed {
        logic [60:0] num;
        logic [30:0] rem;
        logic [30:0] den;
        logic [31:0] q;
    } div_t;

    // normalised axis data travelling beside the root and divide chains
    typedef struct packed {
        logic [2:0][29:0] m;
        logic [2:0]       neg;
        logic             zero;
    } ax_side_t;

    typedef struct packed {
        q_t c;
        q_t s;
    } sc_t;

    // arctangent of 2^-i in signed q4.30
    function automatic q_t atan_q30(input int unsigned i);
        q_t v;
        case (i)
            0: v = 34'sd843314856;
            1: v = 34'sd497837829;
            2: v = 34'sd263043836;
            3: v = 34'sd133525158;
            4: v = 34'sd67021686;
            5: v = 34'sd33543515;
            6: v = 34'sd16775850;
            7: v = 34'sd8388437;
            8: v = 34'sd4194282;
            9: v = 34'sd2097149;
            default:
            begin
                if (i < 30)
                    v = q_t'((64'd1 << (30 - i)) - 64'd1);
                else
                    v = '0;
            end
        endcase
        return v;
    endfunction

    // rounded signed q4.30 product
    function automatic q_t mulq(input q_t a, input q_t b);
        logic signed [67:0] p;
        p = a * b + 68'sd536870912;
        return p[63:30];
    endfunction

    function automatic q_t clamp_one(input q_t v);
        q_t r;
        if (v > Q_ONE)
            r = Q_ONE;
        else if (v < Q_MONE)
            r = Q_MONE;
        else
            r = v;
        return r;
    endfunction

endpackage

// ===== rtl/aart_cordic_cell.sv =====
module aart_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic              clk,
    input  aart_pkg::cord_t   din,
    output aart_pkg::cord_t   dout
);

    localparam aart_pkg::q_t ATAN = aart_pkg::atan_q30(IDX);

    aart_pkg::cord_t dout_next;
    aart_pkg::cord_t dout_reg;
    aart_pkg::q_t    sx;
    aart_pkg::q_t    sy;

    // one micro-rotation towards zero residual angle
    always_comb
    begin
        sx = din.x >>> IDX;
        sy = din.y >>> IDX;
        dout_next.flip = din.flip;
        if (din.z >= 0)
        begin
            dout_next.x = din.x - sy;
            dout_next.y = din.y + sx;
            dout_next.z = din.z - ATAN;
        end
        else
        begin
            dout_next.x = din.x + sy;
            dout_next.y = din.y - sx;
            dout_next.z = din.z + ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

// ===== rtl/aart_sqrt_cell.sv =====
module aart_sqrt_cell #(
    parameter int BIT_POS = 62
) (
    input  logic              clk,
    input  aart_pkg::sqrt_t   din,
    output aart_pkg::sqrt_t   dout
);

    localparam logic [62:0] BIT = 63'd1 << BIT_POS;

    aart_pkg::sqrt_t dout_next;
    aart_pkg::sqrt_t dout_reg;
    logic [62:0]     trial;

    // one root bit: subtract the trial square when it fits
    always_comb
    begin
        trial = din.r + BIT;
        if (din.x >= trial)
        begin
            dout_next.x = din.x - trial;
            dout_next.r = (din.r >> 1) + BIT;
        end
        else
        begin
            dout_next.x = din.x;
            dout_next.r = din.r >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

// ===== rtl/aart_div_cell.sv =====
module aart_div_cell #(
    parameter int BIT_POS = 31
) (
    input  logic             clk,
    input  aart_pkg::div_t   din,
    output aart_pkg::div_t   dout
);

    aart_pkg::div_t dout_next;
    aart_pkg::div_t dout_reg;
    logic [31:0]    trial;

    // one restoring quotient bit
    always_comb
    begin
        trial     = {din.rem, din.num[BIT_POS]};
        dout_next = din;
        if (trial >= {1'b0, din.den})
        begin
            dout_next.rem        = 31'(trial - {1'b0, din.den});
            dout_next.q[BIT_POS] = 1'b1;
        end
        else
        begin
            dout_next.rem        = trial[30:0];
            dout_next.q[BIT_POS] = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

// ===== rtl/axis_angle_rotation_transform.sv =====
// a result strobes on done once its request has passed the full pipeline, which holds
// the 32-cell root chain and the 32-cell divide chains of the axis path
// throughput: one request per cycle, busy stays low, results cannot be held off
// reset: rst_n clears the valid chain at once; no clearing pass, first request
// may follow the release of reset in the next cycle
module axis_angle_rotation_transform #(
    parameter int CORDIC_STAGES = 28
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  aart_pkg::req_t   req,
    output logic             done,
    output aart_pkg::res_t   res
);

    localparam int CSD_LEN  = aart_pkg::L_U - CORDIC_STAGES - 1;
    localparam int SIDE_LEN = aart_pkg::L_QUO - aart_pkg::L_SIDE + 1;
    localparam int V1_LEN   = aart_pkg::L_U + 3;
    localparam int OUT_W    = aart_pkg::COORD_WIDTH;

    typedef logic signed [OUT_W-1:0] crd_t;

    // request valid chain
    logic [aart_pkg::L_OUT:1] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[aart_pkg::L_OUT-1:1], start};
    end

    assign busy = 1'b0;
    assign done = vld_reg[aart_pkg::L_OUT];

    // stage 1: axis difference as sign and magnitude, angle fold
    crd_t               p1 [3];
    crd_t               p2 [3];
    logic signed [OUT_W:0] diff [3];
    logic signed [OUT_W:0] absd [3];
    logic [OUT_W-1:0]   mag_next [3];
    logic [2:0]         neg_next;
    aart_pkg::q_t       z0;
    aart_pkg::cord_t    cord_next;

    always_comb
    begin
        p1[0] = req.first_point_x;
        p1[1] = req.first_point_y;
        p1[2] = req.first_point_z;
        p2[0] = req.second_point_x;
        p2[1] = req.second_point_y;
        p2[2] = req.second_point_z;
        for (int i = 0; i < 3; i++)
        begin
            diff[i]     = p2[i] - p1[i];
            neg_next[i] = diff[i][OUT_W];
            absd[i]     = neg_next[i] ? -diff[i] : diff[i];
            mag_next[i] = absd[i][OUT_W-1:0];
        end
        z0 = $signed({req.rot_angle[31], req.rot_angle, 1'b0});
        cord_next.x    = aart_pkg::Q_GAIN;
        cord_next.y    = '0;
        cord_next.flip = 1'b0;
        cord_next.z    = z0;
        if (z0 > aart_pkg::Q_HALF_PI)
        begin
            cord_next.z    = z0 - aart_pkg::Q_PI;
            cord_next.flip = 1'b1;
        end
        else if (z0 < -aart_pkg::Q_HALF_PI)
        begin
            cord_next.z    = z0 + aart_pkg::Q_PI;
            cord_next.flip = 1'b1;
        end
    end

    logic [OUT_W-1:0] s1_mag_reg [3];
    logic [2:0]       s1_neg_reg;
    aart_pkg::cord_t  cdc [0:CORDIC_STAGES];
    aart_pkg::cord_t  cord_reg;

    always_ff @(posedge clk)
    begin
        s1_mag_reg <= mag_next;
        s1_neg_reg <= neg_next;
        cord_reg   <= cord_next;
    end

    assign cdc[0] = cord_reg;

    // stage 2: leading one of the largest component
    logic [OUT_W-1:0]         mx;
    logic [$clog2(OUT_W)-1:0] top_next;

    always_comb
    begin
        mx       = s1_mag_reg[0] | s1_mag_reg[1] | s1_mag_reg[2];
        top_next = '0;
        for (int i = 0; i < OUT_W; i++)
        begin
            if (mx[i])
                top_next = ($clog2(OUT_W))'(i);
        end
    end

    logic [OUT_W-1:0]         s2_mag_reg [3];
    logic [2:0]               s2_neg_reg;
    logic [$clog2(OUT_W)-1:0] s2_top_reg;
    logic                     s2_zero_reg;

    always_ff @(posedge clk)
    begin
        s2_mag_reg  <= s1_mag_reg;
        s2_neg_reg  <= s1_neg_reg;
        s2_top_reg  <= top_next;
        s2_zero_reg <= (mx == '0);
    end

    // stage 3: common shift to put the top bit at bit 29
    aart_pkg::ax_side_t side_next;
    aart_pkg::ax_side_t side_reg [SIDE_LEN];

    always_comb
    begin
        side_next.neg  = s2_neg_reg;
        side_next.zero = s2_zero_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (int'(s2_top_reg) > 29)
                side_next.m[i] = 30'(s2_mag_reg[i] >> (int'(s2_top_reg) - 29));
            else
                side_next.m[i] = 30'(s2_mag_reg[i] << (29 - int'(s2_top_reg)));
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        for (int i = 1; i < SIDE_LEN; i++)
            side_reg[i] <= side_reg[i-1];
    end

    // stages 4 and 5: squared length
    logic [59:0]     sq_reg [3];
    aart_pkg::sqrt_t sq_in_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            sq_reg[i] <= side_reg[0].m[i] * side_reg[0].m[i];
        sq_in_reg.x <= 63'(sq_reg[0]) + 63'(sq_reg[1]) + 63'(sq_reg[2]);
        sq_in_reg.r <= '0;
    end

    // square root chain, one root bit per cell
    aart_pkg::sqrt_t sqc [0:aart_pkg::SQRT_CELLS];

    assign sqc[0] = sq_in_reg;

    for (genvar j = 0; j < aart_pkg::SQRT_CELLS; j++)
    begin : g_sqrt
        aart_sqrt_cell #(
            .BIT_POS(62 - 2 * j)
        ) u_cell (
            .clk  (clk),
            .din  (sqc[j]),
            .dout (sqc[j+1])
        );
    end

    // numerators with half the length for rounding
    logic [30:0]     root;
    aart_pkg::div_t  div_next [3];
    aart_pkg::div_t  div_in_reg [3];

    always_comb
    begin
        root = sqc[aart_pkg::SQRT_CELLS].r[30:0];
        for (int i = 0; i < 3; i++)
        begin
            div_next[i].num = (61'(side_reg[aart_pkg::L_ROOT - aart_pkg::L_SIDE].m[i]) << 30)
                              + 61'(root[30:1]);
            div_next[i].den = root;
            div_next[i].rem = 31'(div_next[i].num[60:32]);
            div_next[i].q   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        div_in_reg <= div_next;
    end

    // divide chains, one per axis component
    aart_pkg::div_t dvc [3][0:aart_pkg::DIV_CELLS];

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        assign dvc[l][0] = div_in_reg[l];
        for (genvar j = 0; j < aart_pkg::DIV_CELLS; j++)
        begin : g_div
            aart_div_cell #(
                .BIT_POS(aart_pkg::DIV_CELLS - 1 - j)
            ) u_cell (
                .clk  (clk),
                .din  (dvc[l][j]),
                .dout (dvc[l][j+1])
            );
        end
    end

    // unit axis, x axis when both points coincide
    aart_pkg::ax_side_t side_u;
    aart_pkg::q_t       u_next [3];
    aart_pkg::q_t       uv [3];
    aart_pkg::q_t       u_reg [3];

    always_comb
    begin
        side_u = side_reg[aart_pkg::L_QUO - aart_pkg::L_SIDE];
        for (int i = 0; i < 3; i++)
        begin
            if (dvc[i][aart_pkg::DIV_CELLS].q > 32'd1073741824)
                uv[i] = aart_pkg::Q_ONE;
            else
                uv[i] = $signed({2'b00, dvc[i][aart_pkg::DIV_CELLS].q});
            u_next[i] = side_u.neg[i] ? -uv[i] : uv[i];
        end
        if (side_u.zero)
        begin
            u_next[0] = aart_pkg::Q_ONE;
            u_next[1] = '0;
            u_next[2] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg <= u_next;
    end

    // cordic chain for cosine and sine
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        aart_cordic_cell #(
            .IDX(i)
        ) u_cell (
            .clk  (clk),
            .din  (cdc[i]),
            .dout (cdc[i+1])
        );
    end

    aart_pkg::sc_t sc_next;
    aart_pkg::sc_t csd_reg [CSD_LEN];

    always_comb
    begin
        if (cdc[CORDIC_STAGES].flip)
        begin
            sc_next.c = aart_pkg::clamp_one(-cdc[CORDIC_STAGES].x);
            sc_next.s = aart_pkg::clamp_one(-cdc[CORDIC_STAGES].y);
        end
        else
        begin
            sc_next.c = aart_pkg::clamp_one(cdc[CORDIC_STAGES].x);
            sc_next.s = aart_pkg::clamp_one(cdc[CORDIC_STAGES].y);
        end
    end

    // hold cosine and sine until the axis is ready
    always_ff @(posedge clk)
    begin
        csd_reg[0] <= sc_next;
        for (int i = 1; i < CSD_LEN; i++)
            csd_reg[i] <= csd_reg[i-1];
    end

    // first point delay line for the translation
    crd_t v1d_reg [V1_LEN][3];

    always_ff @(posedge clk)
    begin
        v1d_reg[0][0] <= req.first_point_x;
        v1d_reg[0][1] <= req.first_point_y;
        v1d_reg[0][2] <= req.first_point_z;
        for (int i = 1; i < V1_LEN; i++)
            v1d_reg[i] <= v1d_reg[i-1];
    end

    // product stage 1: axis products and sine terms
    aart_pkg::q_t p1_sq_reg [3];
    aart_pkg::q_t p1_us_reg [3];
    aart_pkg::q_t p1_pxy_reg;
    aart_pkg::q_t p1_pxz_reg;
    aart_pkg::q_t p1_pyz_reg;
    aart_pkg::q_t p1_k_reg;
    aart_pkg::q_t p1_c_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            p1_sq_reg[i] <= aart_pkg::mulq(u_reg[i], u_reg[i]);
            p1_us_reg[i] <= aart_pkg::mulq(u_reg[i], csd_reg[CSD_LEN-1].s);
        end
        p1_pxy_reg <= aart_pkg::mulq(u_reg[0], u_reg[1]);
        p1_pxz_reg <= aart_pkg::mulq(u_reg[0], u_reg[2]);
        p1_pyz_reg <= aart_pkg::mulq(u_reg[1], u_reg[2]);
        p1_k_reg   <= aart_pkg::Q_ONE - csd_reg[CSD_LEN-1].c;
        p1_c_reg   <= csd_reg[CSD_LEN-1].c;
    end

    // product stage 2: cosine and versine terms
    aart_pkg::q_t p2_dm_reg [3];
    aart_pkg::q_t p2_sq_reg [3];
    aart_pkg::q_t p2_us_reg [3];
    aart_pkg::q_t p2_oxy_reg;
    aart_pkg::q_t p2_oxz_reg;
    aart_pkg::q_t p2_oyz_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            p2_dm_reg[i] <= aart_pkg::mulq(aart_pkg::Q_ONE - p1_sq_reg[i], p1_c_reg);
        p2_sq_reg  <= p1_sq_reg;
        p2_us_reg  <= p1_us_reg;
        p2_oxy_reg <= aart_pkg::mulq(p1_pxy_reg, p1_k_reg);
        p2_oxz_reg <= aart_pkg::mulq(p1_pxz_reg, p1_k_reg);
        p2_oyz_reg <= aart_pkg::mulq(p1_pyz_reg, p1_k_reg);
    end

    // product stage 3: matrix entries, clamped
    aart_pkg::q_t       mat_next [9];
    logic signed [31:0] mat_reg [9];

    always_comb
    begin
        mat_next[0] = aart_pkg::clamp_one(p2_sq_reg[0] + p2_dm_reg[0]);
        mat_next[4] = aart_pkg::clamp_one(p2_sq_reg[1] + p2_dm_reg[1]);
        mat_next[8] = aart_pkg::clamp_one(p2_sq_reg[2] + p2_dm_reg[2]);
        mat_next[1] = aart_pkg::clamp_one(p2_oxy_reg - p2_us_reg[2]);
        mat_next[2] = aart_pkg::clamp_one(p2_oxz_reg + p2_us_reg[1]);
        mat_next[3] = aart_pkg::clamp_one(p2_oxy_reg + p2_us_reg[2]);
        mat_next[5] = aart_pkg::clamp_one(p2_oyz_reg - p2_us_reg[0]);
        mat_next[6] = aart_pkg::clamp_one(p2_oxz_reg - p2_us_reg[1]);
        mat_next[7] = aart_pkg::clamp_one(p2_oyz_reg + p2_us_reg[0]);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 9; i++)
            mat_reg[i] <= mat_next[i][31:0];
    end

    // translation stage 1: matrix times first point
    logic signed [OUT_W+31:0] tp_reg [3][3];
    crd_t                     t1_v1_reg [3];

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
            for (int j = 0; j < 3; j++)
                tp_reg[r][j] <= mat_reg[r*3 + j] * v1d_reg[V1_LEN-1][j];
        t1_v1_reg <= v1d_reg[V1_LEN-1];
    end

    // translation stage 2: exact sum
    logic signed [OUT_W+33:0] base [3];
    logic signed [OUT_W+33:0] acc_reg [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
            base[r] = $signed({{4{t1_v1_reg[r][OUT_W-1]}}, t1_v1_reg[r], 30'd0});
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
            acc_reg[r] <= base[r] - tp_reg[r][0] - tp_reg[r][1] - tp_reg[r][2];
    end

    // output stage: round, saturate and register the result
    logic signed [OUT_W+33:0] rnd [3];
    logic signed [OUT_W+3:0]  tv [3];
    crd_t                     sat [3];
    aart_pkg::res_t           res_next;
    aart_pkg::res_t           res_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            rnd[r] = acc_reg[r] + (OUT_W+34)'(536870912);
            tv[r]  = rnd[r][OUT_W+33:30];
            if (tv[r] > $signed((OUT_W+4)'({1'b0, {(OUT_W-1){1'b1}}})))
                sat[r] = {1'b0, {(OUT_W-1){1'b1}}};
            else if (tv[r] < $signed((OUT_W+4)'({{4{1'b1}}, 1'b1, {(OUT_W-1){1'b0}}})))
                sat[r] = {1'b1, {(OUT_W-1){1'b0}}};
            else
                sat[r] = tv[r][OUT_W-1:0];
        end
        res_next.rot_r0c0 = mat_reg[0];
        res_next.rot_r0c1 = mat_reg[1];
        res_next.rot_r0c2 = mat_reg[2];
        res_next.rot_r1c0 = mat_reg[3];
        res_next.rot_r1c1 = mat_reg[4];
        res_next.rot_r1c2 = mat_reg[5];
        res_next.rot_r2c0 = mat_reg[6];
        res_next.rot_r2c1 = mat_reg[7];
        res_next.rot_r2c2 = mat_reg[8];
        res_next.shift_x  = sat[0];
        res_next.shift_y  = sat[1];
        res_next.shift_z  = sat[2];
    end

    // matrix is held in mat_d1_reg and mat_d2_reg so it lines up with the translation
    logic signed [31:0] mat_d1_reg [9];
    logic signed [31:0] mat_d2_reg [9];

    always_ff @(posedge clk)
    begin
        mat_d1_reg <= mat_reg;
        mat_d2_reg <= mat_d1_reg;
    end

    aart_pkg::res_t res_out;

    always_comb
    begin
        res_out          = res_next;
        res_out.rot_r0c0 = mat_d2_reg[0];
        res_out.rot_r0c1 = mat_d2_reg[1];
        res_out.rot_r0c2 = mat_d2_reg[2];
        res_out.rot_r1c0 = mat_d2_reg[3];
        res_out.rot_r1c1 = mat_d2_reg[4];
        res_out.rot_r1c2 = mat_d2_reg[5];
        res_out.rot_r2c0 = mat_d2_reg[6];
        res_out.rot_r2c1 = mat_d2_reg[7];
        res_out.rot_r2c2 = mat_d2_reg[8];
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_out;
    end

    assign res = res_reg;

endmodule

// ===== rtl/aart_checker.sv =====
module aart_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input aart_pkg::req_t   req,
    input logic             done,
    input aart_pkg::res_t   res
);

    localparam int LAT = aart_pkg::L_OUT;

    // every request taken gives a strobe on done
    a_req_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT done)
        else $error("request without result");

    // no result without a request
    a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without request");

    // diagonal entries stay within one
    a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (res.rot_r0c0 <= 32'sd1073741824) && (res.rot_r0c0 >= -32'sd1073741824)
              && (res.rot_r1c1 <= 32'sd1073741824) && (res.rot_r1c1 >= -32'sd1073741824)
              && (res.rot_r2c2 <= 32'sd1073741824) && (res.rot_r2c2 >= -32'sd1073741824))
        else $error("matrix entry out of range");

    // coincident points fall back to the x axis
    a_zero_axis: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(req.first_point_x == req.second_point_x
                      && req.first_point_y == req.second_point_y
                      && req.first_point_z == req.second_point_z, LAT)
        |-> res.rot_r0c0 == 32'sd1073741824 && res.rot_r0c1 == 32'sd0
            && res.rot_r0c2 == 32'sd0)
        else $error("zero axis fallback broken");

endmodule

bind axis_angle_rotation_transform aart_checker u_aart_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .res   (res)
);

// ===== tb/tb_axis_angle_rotation_transform.sv =====
`timescale 1ns / 100ps

module tb_axis_angle_rotation_transform;

    localparam int  LATENCY   = 77;
    localparam int  STAGES    = 28;
    localparam real T_CLK     = 4.0;
    localparam longint ONE    = 64'sd1073741824;
    localparam longint HALF   = 64'sd536870912;
    localparam longint HPI    = 64'sd1686629713;
    localparam longint PI     = 64'sd3373259426;
    localparam longint GAIN   = 64'sd652032874;
    localparam int  ANGLE_MAX = 1686629713;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    aart_pkg::req_t req;
    aart_pkg::res_t res;

    aart_pkg::res_t expected_q[$];
    int   mismatches;
    int   idle_pct;

    axis_angle_rotation_transform #(
        .CORDIC_STAGES(STAGES)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .req  (req),
        .done (done),
        .res  (res)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #(T_CLK / 2.0) clk = ~clk;

    // floor shift of a signed value
    function automatic longint fshr(input longint v, input int s);
        return v >>> s;
    endfunction

    // rounded q2.30 product
    function automatic longint qmul(input longint a, input longint b);
        return fshr(a * b + HALF, 30);
    endfunction

    function automatic longint clip_one(input longint v);
        if (v > ONE)
            return ONE;
        if (v < -ONE)
            return -ONE;
        return v;
    endfunction

    function automatic longint arctan_step(input int i);
        longint tbl[10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                            33543515, 16775850, 8388437, 4194282, 2097149};
        if (i < 10)
            return tbl[i];
        if (i < 30)
            return (64'sd1 << (30 - i)) - 1;
        return 0;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // matrix and translation for one request
    function automatic aart_pkg::res_t rotation_for(input aart_pkg::req_t q);
        longint p1[3];
        longint p2[3];
        longint u[3];
        longint mt[9];
        longint unsigned m[3];
        longint unsigned mx;
        longint unsigned len2;
        longint unsigned n;
        longint unsigned qt;
        bit     ng[3];
        int     top;
        longint z;
        longint x;
        longint y;
        longint nx;
        longint sx;
        longint sy;
        longint c;
        longint s;
        longint k;
        longint uxy;
        longint uxz;
        longint uyz;
        longint sq;
        bit     flip;
        logic signed [127:0] acc;
        logic signed [127:0] rnd;
        longint t;
        aart_pkg::res_t o;
        p1 = '{q.first_point_x, q.first_point_y, q.first_point_z};
        p2 = '{q.second_point_x, q.second_point_y, q.second_point_z};
        // unit axis
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            ng[i] = p2[i] < p1[i];
            m[i] = ng[i] ? longint'(p1[i] - p2[i]) : longint'(p2[i] - p1[i]);
            if (m[i] > mx)
                mx = m[i];
        end
        if (mx == 0)
            u = '{ONE, 0, 0};
        else
        begin
            top = 0;
            for (int i = 63; i > 0; i--)
                if (mx[i] && top == 0)
                    top = i;
            len2 = 0;
            for (int i = 0; i < 3; i++)
            begin
                m[i] = (top > 29) ? (m[i] >> (top - 29)) : (m[i] << (29 - top));
                len2 += m[i] * m[i];
            end
            n = int_sqrt(len2);
            for (int i = 0; i < 3; i++)
            begin
                qt = ((m[i] << 30) + (n >> 1)) / n;
                u[i] = (qt > ONE) ? ONE : longint'(qt);
                if (ng[i])
                    u[i] = -u[i];
            end
        end
        // sine and cosine
        z = longint'(q.rot_angle) * 2;
        flip = 1'b0;
        if (z > HPI)
        begin
            z -= PI;
            flip = 1'b1;
        end
        else if (z < -HPI)
        begin
            z += PI;
            flip = 1'b1;
        end
        x = GAIN;
        y = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            sx = fshr(x, i);
            sy = fshr(y, i);
            if (z >= 0)
            begin
                nx = x - sy;
                y = y + sx;
                z -= arctan_step(i);
            end
            else
            begin
                nx = x + sy;
                y = y - sx;
                z += arctan_step(i);
            end
            x = nx;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = clip_one(x);
        s = clip_one(y);
        // rodrigues matrix
        k = ONE - c;
        uxy = qmul(qmul(u[0], u[1]), k);
        uxz = qmul(qmul(u[0], u[2]), k);
        uyz = qmul(qmul(u[1], u[2]), k);
        for (int i = 0; i < 3; i++)
        begin
            sq = qmul(u[i], u[i]);
            mt[i * 4] = sq + qmul(ONE - sq, c);
        end
        mt[1] = uxy - qmul(u[2], s);
        mt[2] = uxz + qmul(u[1], s);
        mt[3] = uxy + qmul(u[2], s);
        mt[5] = uyz - qmul(u[0], s);
        mt[6] = uxz - qmul(u[1], s);
        mt[7] = uyz + qmul(u[0], s);
        for (int i = 0; i < 9; i++)
            mt[i] = clip_one(mt[i]);
        o.rot_r0c0 = 32'(mt[0]);
        o.rot_r0c1 = 32'(mt[1]);
        o.rot_r0c2 = 32'(mt[2]);
        o.rot_r1c0 = 32'(mt[3]);
        o.rot_r1c1 = 32'(mt[4]);
        o.rot_r1c2 = 32'(mt[5]);
        o.rot_r2c0 = 32'(mt[6]);
        o.rot_r2c1 = 32'(mt[7]);
        o.rot_r2c2 = 32'(mt[8]);
        // translation, saturated
        for (int r = 0; r < 3; r++)
        begin
            acc = 128'(p1[r]) * 128'(ONE);
            for (int i = 0; i < 3; i++)
                acc -= 128'(p1[i]) * 128'(mt[r * 3 + i]);
            rnd = (acc + 128'(HALF)) >>> 30;
            if (rnd > 128'sd2147483647)
                t = 64'sd2147483647;
            else if (rnd < -128'sd2147483648)
                t = -64'sd2147483648;
            else
                t = longint'(rnd);
            if (r == 0)
                o.shift_x = 32'(t);
            else if (r == 1)
                o.shift_y = 32'(t);
            else
                o.shift_z = 32'(t);
        end
        return o;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 2000) - 1000;
            1: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            2: return {$urandom_range(0, 1) ? 2'b01 : 2'b10, 30'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_angle();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 2) == 0 ? ANGLE_MAX : -ANGLE_MAX;
        return $urandom_range(0, 2 * unsigned'(ANGLE_MAX)) - ANGLE_MAX;
    endfunction

    // send one request; start stays high so the next can follow at once
    task automatic send_request(input aart_pkg::req_t q);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        req   <= q;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_q.push_back(rotation_for(q));
        @(negedge clk);
    endtask

    task automatic send_points(input logic [31:0] a, input logic [31:0] x1,
                               input logic [31:0] y1, input logic [31:0] z1,
                               input logic [31:0] x2, input logic [31:0] y2,
                               input logic [31:0] z2);
        aart_pkg::req_t q;
        q = {a, x1, y1, z1, x2, y2, z2};
        send_request(q);
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_drained();
        start <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
    endtask

    // directed corners: zero axis, each axis, angle limits, coordinate extremes
    task automatic test_directed();
        logic [31:0] mn;
        logic [31:0] mxv;
        mn  = 32'h8000_0000;
        mxv = 32'h7FFF_FFFF;
        send_points(0, 0, 0, 0, 0, 0, 0);
        send_points(ANGLE_MAX / 2, 5, 6, 7, 5, 6, 7);
        send_points(ANGLE_MAX, 0, 0, 0, 32'h10000, 0, 0);
        send_points(-ANGLE_MAX, 0, 0, 0, 0, 32'h10000, 0);
        send_points(ANGLE_MAX / 2, 0, 0, 0, 0, 0, 32'h10000);
        send_points(-ANGLE_MAX / 2, 0, 0, 0, 0, 0, -32'h10000);
        send_points(ANGLE_MAX / 4, 0, 0, 0, 1, 1, 1);
        send_points(32'h7FFF_FFFF, 32'h10000, 0, 0, 32'h10000, 32'h10000, 0);
        send_points(32'h8000_0000, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000);
        send_points(ANGLE_MAX / 3, mn, mn, mn, mxv, mxv, mxv);
        send_points(-ANGLE_MAX / 3, mxv, mxv, mxv, mn, mn, mn);
        send_points(ANGLE_MAX, mxv, mn, mxv, mxv, mn, mn);
        send_points(ANGLE_MAX / 2, mxv, mxv, 0, mxv, 0, 0);
        send_points(ANGLE_MAX / 2, mn, mn, mn, mn, mn, mxv);
        send_points(-ANGLE_MAX, mn, mxv, mn, mn, mxv, 32'h0000_0001);
        send_points(1, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F,
                    32'hF0F0F0F0, 32'h55555555, 32'hAAAAAAAA);
        send_points(-1, 32'hFFFF_FFFF, 1, 0, 32'hFFFF_FFFE, 2, 1);
        send_points(ANGLE_MAX, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000,
                    32'h4000_0001, 32'h4000_0000, 32'h4000_0000);
    endtask

    // random requests in bursts with and without idling
    task automatic test_random(input int count, input int pct);
        idle_pct = pct;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_points(rand_angle(), rand_coord(), rand_coord(), rand_coord(),
                            $urandom, $urandom, $urandom);
            else if ($urandom_range(0, 15) == 0)
                send_points(rand_angle(), 32'($urandom_range(0, 7)), 0, 0,
                            32'($urandom_range(0, 7)), 0, 0);
            else
                send_points(rand_angle(), rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), rand_coord(), rand_coord());
        end
        idle_pct = 0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        aart_pkg::res_t e;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", res);
            end
            else
            begin
                e = expected_q.pop_front();
                if (res !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", e, res);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int extra;
        mismatches = 0;
        idle_pct   = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        wait_drained();
        test_random(450, 8);
        test_random(300, 0);
        wait_drained();
        test_random(380, 8);
        wait_drained();
        extra = 0;
        while (extra < LATENCY + 10)
        begin
            @(negedge clk);
            extra++;
        end
        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb_axis_angle_rotation_transform: clean");
        else
            $display("tb_axis_angle_rotation_transform: errors");
        $finish;
    end

    // run limit
    initial
    begin
        #(2_000_000);
        $display("tb_axis_angle_rotation_transform: errors");
        $finish;
    end

endmodule
